// ----- hdl/lrfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrfs_pkg
// Types and constants shared by the log record field splitter.
// ----------------------------------------------------------------------------
package lrfs_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	localparam logic KIND_BRACKET = 1'b0;
	localparam logic KIND_QUOTE   = 1'b1;

	localparam int          FIELD_W            = 6;
	localparam logic [5:0]  EXPECTED_RESET     = 6'd9;
	localparam logic [5:0]  FIELD_COUNT_MAX    = 6'd63;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_MANY   = 3'd1,
		ST_WRONG_CNT  = 3'd2,
		ST_UNMATCHED  = 3'd3,
		ST_OVERFLOW   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] record_byte;
		logic       record_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         echo_byte;
		logic [FIELD_W-1:0] field_number;
		logic               byte_in_field;
		logic               field_done;
		logic               record_done;
		status_t            status;
	} out_item_t;

endpackage

// ----- hdl/log_record_field_splitter_top.sv -----
// ----------------------------------------------------------------------------
// log_record_field_splitter_top
// Splits a log record, one byte per request, into space separated fields.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one record byte per request, the
//     byte flagged record_last ends the record and is not field text.
//   out channel (out_valid/out_ready/out_data): exactly one result per byte,
//     in order, echoing the byte with its field index and flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): expected field count, always
//     ready; write it only while the block is idle.
// An accepted request is held in the input register; the split logic then
// updates the record state and loads the result register from it.
// Throughput is one byte per cycle while the receiver takes results; the record
// state (nesting stack, field count, quote flags) is updated once per byte.
// A stalled receiver holds the result register; the input register still
// takes one more byte, then in_ready drops until the result is taken.
// Reset clears the record state and sets the expected count to 9; the stack
// contents are not cleared since only entries below the depth are read.
// ----------------------------------------------------------------------------
module log_record_field_splitter_top #(
	parameter int STACK_DEPTH = 8,
	parameter int MAX_FIELDS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  lrfs_pkg::in_item_t  in_data,

	output logic                out_valid,
	input  logic                out_ready,
	output lrfs_pkg::out_item_t out_data,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [5:0]          cfg_data
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int EW = lrfs_pkg::FIELD_W + 1;

	// input stage
	lrfs_pkg::in_item_t  in_s1;
	logic                in_valid_s1;

	// result stage
	lrfs_pkg::out_item_t res_s2;
	logic                res_valid_s2;

	// record state
	logic [STACK_DEPTH-1:0]       stack_q;
	logic [DW-1:0]                depth_q;
	logic [lrfs_pkg::FIELD_W-1:0] fields_q;
	logic                         prev_space_q;
	logic                         pend_q;
	logic                         disc_q;
	logic [5:0]                   expect_cfg_q;

	logic                         advance;

	logic [STACK_DEPTH-1:0]       stack_n;
	logic [DW-1:0]                depth_n;
	logic [lrfs_pkg::FIELD_W-1:0] fields_n;
	logic                         prev_space_n;
	logic                         pend_n;
	logic                         disc_n;
	lrfs_pkg::out_item_t          res_n;

	logic [7:0]                   b;
	logic                         last;
	logic [EW-1:0]                expect_w;
	lrfs_pkg::status_t            err;
	logic                         in_field;
	logic                         fdone;

	assign advance   = in_valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	always_comb begin
		b            = in_s1.record_byte;
		last         = in_s1.record_last;
		expect_w     = (EW'(expect_cfg_q) < EW'(MAX_FIELDS)) ? EW'(expect_cfg_q)
		                                                     : EW'(MAX_FIELDS);
		err          = lrfs_pkg::ST_OK;
		in_field     = 1'b0;
		fdone        = 1'b0;
		stack_n      = stack_q;
		depth_n      = depth_q;
		fields_n     = fields_q;
		prev_space_n = prev_space_q;
		pend_n       = pend_q;
		disc_n       = disc_q;

		if (!disc_q) begin
			// a quote closes only when followed by a space
			if (pend_q) begin
				pend_n = 1'b0;
				if (b == lrfs_pkg::CH_SPACE) begin
					if (depth_q == '0) begin
						err = lrfs_pkg::ST_UNMATCHED;
					end else if (stack_q[0] == lrfs_pkg::KIND_QUOTE) begin
						depth_n = depth_q - DW'(1);
						stack_n = {stack_q[STACK_DEPTH-1], stack_q[STACK_DEPTH-1:1]};
					end
				end
			end
			if (err == lrfs_pkg::ST_OK && EW'(fields_q) > expect_w) begin
				err = lrfs_pkg::ST_TOO_MANY;
			end
			if (err == lrfs_pkg::ST_OK && last) begin
				if (EW'(fields_q) + EW'(1) != expect_w) begin
					err = lrfs_pkg::ST_WRONG_CNT;
				end else begin
					fdone = 1'b1;
				end
			end
			if (err == lrfs_pkg::ST_OK && !last) begin
				in_field = 1'b1;
				priority if (b == lrfs_pkg::CH_SPACE) begin
					if (depth_n == '0) begin
						in_field = 1'b0;
						fdone    = 1'b1;
						if (fields_q != lrfs_pkg::FIELD_COUNT_MAX) begin
							fields_n = fields_q + lrfs_pkg::FIELD_W'(1);
						end
					end
				end else if (b == lrfs_pkg::CH_QUOTE) begin
					if (prev_space_q) begin
						if (depth_n >= DW'(STACK_DEPTH)) begin
							err = lrfs_pkg::ST_OVERFLOW;
						end else begin
							stack_n = {stack_n[STACK_DEPTH-2:0], lrfs_pkg::KIND_QUOTE};
							depth_n = depth_n + DW'(1);
						end
					end else begin
						pend_n = 1'b1;
					end
				end else if (b == lrfs_pkg::CH_OPEN) begin
					if (depth_n >= DW'(STACK_DEPTH)) begin
						err = lrfs_pkg::ST_OVERFLOW;
					end else begin
						stack_n = {stack_n[STACK_DEPTH-2:0], lrfs_pkg::KIND_BRACKET};
						depth_n = depth_n + DW'(1);
					end
				end else if (b == lrfs_pkg::CH_CLOSE) begin
					if (depth_n == '0) begin
						err = lrfs_pkg::ST_UNMATCHED;
					end else if (stack_n[0] == lrfs_pkg::KIND_BRACKET) begin
						depth_n = depth_n - DW'(1);
						stack_n = {stack_n[STACK_DEPTH-1], stack_n[STACK_DEPTH-1:1]};
					end
				end else begin
					in_field = 1'b1;
				end
				prev_space_n = (b == lrfs_pkg::CH_SPACE);
			end
			if (err != lrfs_pkg::ST_OK) begin
				in_field = 1'b0;
				fdone    = 1'b0;
				disc_n   = 1'b1;
			end
		end

		if (last) begin
			depth_n      = '0;
			fields_n     = '0;
			prev_space_n = 1'b0;
			pend_n       = 1'b0;
			disc_n       = 1'b0;
		end

		res_n.echo_byte     = b;
		res_n.field_number  = fields_q;
		res_n.byte_in_field = in_field;
		res_n.field_done    = fdone;
		res_n.record_done   = last;
		res_n.status        = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
			depth_q      <= '0;
			fields_q     <= '0;
			prev_space_q <= 1'b0;
			pend_q       <= 1'b0;
			disc_q       <= 1'b0;
			expect_cfg_q <= lrfs_pkg::EXPECTED_RESET;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
				depth_q      <= depth_n;
				fields_q     <= fields_n;
				prev_space_q <= prev_space_n;
				pend_q       <= pend_n;
				disc_q       <= disc_n;
			end else if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				expect_cfg_q <= cfg_data;
			end
		end
	end

	// payload and stack contents need no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			res_s2  <= res_n;
			stack_q <= stack_n;
		end
	end

endmodule

// ----- tb/sv/tb_log_record_field_splitter_top.sv -----
// ----------------------------------------------------------------------------
// tb_log_record_field_splitter_top
// Self-checking bench for the log record field splitter. Records are built as
// byte streams (well-formed fields, off-by-one field counts and raw noise),
// driven through the input request channel and predicted byte by byte by a
// local model of the splitter. Every result is compared field by field, in
// order, while both sides stall at random in all but the last two phases, and
// the expected field count is changed between phases.
// ----------------------------------------------------------------------------
module tb_log_record_field_splitter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_LIMIT = 8;
	localparam int FIELD_LIMIT = 32;
	localparam int SETTLE_CYCLES = 6;

	logic clk;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	lrfs_pkg::in_item_t in_data = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	lrfs_pkg::out_item_t out_data;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;

	// predictor state
	logic nest_kind [STACK_LIMIT];
	int nest_top;
	int fields_seen;
	logic prev_space;
	logic close_pending;
	logic discarding;
	logic [5:0] expected_cfg = lrfs_pkg::EXPECTED_RESET;

	lrfs_pkg::in_item_t record_bytes [$];
	lrfs_pkg::out_item_t expected_splits [$];
	lrfs_pkg::out_item_t want;

	int sender_idle_pct = 9;
	int receiver_idle_pct = 59;
	int mismatch_count = 0;
	int results_checked = 0;
	int bytes_sent = 0;
	int records_sent = 0;
	int bytes_queued = 0;
	int cfg_writes = 0;
	int status_count [5] = '{default: 0};

	log_record_field_splitter_top #(
		.STACK_DEPTH(STACK_LIMIT),
		.MAX_FIELDS (FIELD_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void clear_record_state();
		nest_top = 0;
		fields_seen = 0;
		prev_space = 1'b0;
		close_pending = 1'b0;
		discarding = 1'b0;
	endfunction

	function automatic lrfs_pkg::status_t push_nest(input logic kind);
		if (nest_top >= STACK_LIMIT)
			return lrfs_pkg::ST_OVERFLOW;
		nest_kind[nest_top] = kind;
		nest_top++;
		return lrfs_pkg::ST_OK;
	endfunction

	// one accepted byte in, one expected result out; updates the record state
	function automatic lrfs_pkg::out_item_t predict_split(input lrfs_pkg::in_item_t item);
		lrfs_pkg::out_item_t r;
		int limit;
		logic [7:0] b;
		b = item.record_byte;
		limit = (expected_cfg < FIELD_LIMIT) ? int'(expected_cfg) : FIELD_LIMIT;
		r = '0;
		r.echo_byte = b;
		r.field_number = fields_seen[5:0];
		r.record_done = item.record_last;
		r.status = lrfs_pkg::ST_OK;
		if (!discarding) begin
			// a quote seen last byte closes only if this byte is a space
			if (close_pending) begin
				close_pending = 1'b0;
				if (b == lrfs_pkg::CH_SPACE) begin
					if (nest_top == 0)
						r.status = lrfs_pkg::ST_UNMATCHED;
					else if (nest_kind[nest_top - 1] == lrfs_pkg::KIND_QUOTE)
						nest_top--;
				end
			end
			if (r.status == lrfs_pkg::ST_OK && fields_seen > limit)
				r.status = lrfs_pkg::ST_TOO_MANY;
			if (r.status == lrfs_pkg::ST_OK && item.record_last) begin
				if (fields_seen + 1 != limit)
					r.status = lrfs_pkg::ST_WRONG_CNT;
				else
					r.field_done = 1'b1;
			end
			if (r.status == lrfs_pkg::ST_OK && !item.record_last) begin
				r.byte_in_field = 1'b1;
				if (b == lrfs_pkg::CH_SPACE) begin
					if (nest_top == 0) begin
						r.byte_in_field = 1'b0;
						r.field_done = 1'b1;
						if (fields_seen < lrfs_pkg::FIELD_COUNT_MAX)
							fields_seen++;
					end
				end else if (b == lrfs_pkg::CH_QUOTE) begin
					if (prev_space)
						r.status = push_nest(lrfs_pkg::KIND_QUOTE);
					else
						close_pending = 1'b1;
				end else if (b == lrfs_pkg::CH_OPEN) begin
					r.status = push_nest(lrfs_pkg::KIND_BRACKET);
				end else if (b == lrfs_pkg::CH_CLOSE) begin
					if (nest_top == 0)
						r.status = lrfs_pkg::ST_UNMATCHED;
					else if (nest_kind[nest_top - 1] == lrfs_pkg::KIND_BRACKET)
						nest_top--;
				end
				prev_space = (b == lrfs_pkg::CH_SPACE);
			end
			if (r.status != lrfs_pkg::ST_OK) begin
				r.byte_in_field = 1'b0;
				r.field_done = 1'b0;
				discarding = 1'b1;
			end
		end
		if (item.record_last)
			clear_record_state();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		mismatch_count++;
		$display("%0t: result %0d %s: got %0h, expected %0h",
			$realtime, results_checked, what, got, exp_val);
	endtask

	task automatic check_field(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	// sender: requests come from record_bytes, expectations made on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_splits.insert(expected_splits.size(), predict_split(in_data));
				bytes_sent++;
				if (in_data.record_last)
					records_sent++;
			end
			if (!in_valid || in_ready) begin
				if (record_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_data <= record_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_splits.size() == 0) begin
					report_mismatch("arrived with nothing pending", out_data.echo_byte, 8'h00);
				end else begin
					want = expected_splits.pop_front();
					check_field("echo_byte", out_data.echo_byte, want.echo_byte);
					check_field("field_number", 8'(out_data.field_number),
						8'(want.field_number));
					check_field("byte_in_field", 8'(out_data.byte_in_field),
						8'(want.byte_in_field));
					check_field("field_done", 8'(out_data.field_done), 8'(want.field_done));
					check_field("record_done", 8'(out_data.record_done), 8'(want.record_done));
					check_field("status", 8'(out_data.status), 8'(want.status));
					status_count[want.status]++;
				end
				results_checked++;
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	task automatic wait_idle();
		while (record_bytes.size() != 0 || in_valid || expected_splits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_expected(input logic [5:0] count);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do
			@(posedge clk);
		while (!cfg_ready);
		expected_cfg = count;
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
		lrfs_pkg::in_item_t item;
		item.record_byte = b;
		item.record_last = last;
		record_bytes = {record_bytes, item};
		bytes_queued++;
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == lrfs_pkg::CH_SPACE || c == lrfs_pkg::CH_QUOTE ||
			c == lrfs_pkg::CH_OPEN || c == lrfs_pkg::CH_CLOSE);
		return c;
	endfunction

	// words of plain characters joined by single spaces
	task automatic add_words(input int words);
		for (int w = 0; w < words; w++) begin
			if (w != 0)
				add_byte(lrfs_pkg::CH_SPACE);
			repeat ($urandom_range(1, 3)) add_byte(plain_char());
		end
	endtask

	// a record of the given field count; closers sometimes dropped
	task automatic queue_record(input int nfields);
		logic drop;
		for (int f = 0; f < nfields; f++) begin
			drop = ($urandom_range(19) == 0);
			if (f != 0)
				add_byte(lrfs_pkg::CH_SPACE);
			case ($urandom_range(3))
				0: add_words(1);
				1: begin
					add_byte(lrfs_pkg::CH_OPEN);
					add_words($urandom_range(1, 2));
					if ($urandom_range(2) == 0) begin
						// quoted span nested in the bracket
						add_byte(lrfs_pkg::CH_SPACE);
						add_byte(lrfs_pkg::CH_QUOTE);
						add_words($urandom_range(1, 2));
						add_byte(lrfs_pkg::CH_QUOTE);
						add_byte(lrfs_pkg::CH_SPACE);
						add_words(1);
					end
					if (!drop)
						add_byte(lrfs_pkg::CH_CLOSE);
				end
				2: begin
					if (f == 0) begin
						add_words(1);
					end else begin
						add_byte(lrfs_pkg::CH_QUOTE);
						add_words($urandom_range(1, 3));
						if (!drop)
							add_byte(lrfs_pkg::CH_QUOTE);
					end
				end
				default: begin
					// quote inside a word never opens a span
					add_words(1);
					add_byte(lrfs_pkg::CH_QUOTE);
					add_words(1);
				end
			endcase
		end
		if ($urandom_range(3) == 0)
			add_byte(lrfs_pkg::CH_SPACE, 1'b1);
		else
			add_byte(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(4))
				0: add_byte(lrfs_pkg::CH_SPACE);
				1: add_byte(lrfs_pkg::CH_QUOTE);
				2: add_byte(lrfs_pkg::CH_OPEN);
				3: add_byte(lrfs_pkg::CH_CLOSE);
				default: add_byte(8'($urandom_range(255)));
			endcase
		end
		add_byte(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		logic [5:0] phase_cfg [6];
		int phase_items [6];
		int target;
		int start_count;
		int pick;

		phase_cfg = '{6'd1, 6'd5, 6'd32, 6'd0, 6'd63, 6'($urandom_range(2, 12))};
		phase_items = '{70, 80, 110, 40, 100, 60};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_expected(6'd3);

		// quote at record start, pending close settled on the last byte
		add_byte(lrfs_pkg::CH_QUOTE);
		add_byte("x");
		add_byte(lrfs_pkg::CH_QUOTE);
		add_byte(lrfs_pkg::CH_SPACE, 1'b1);
		// three good fields: word, quoted span, bracket
		add_byte("a");
		add_byte(lrfs_pkg::CH_SPACE);
		add_byte(lrfs_pkg::CH_QUOTE);
		add_byte("b");
		add_byte(lrfs_pkg::CH_QUOTE);
		add_byte(lrfs_pkg::CH_SPACE);
		add_byte(lrfs_pkg::CH_OPEN);
		add_byte("c");
		add_byte(lrfs_pkg::CH_CLOSE);
		add_byte(8'h00, 1'b1);
		// lone last byte, wrong field count
		add_byte(8'hFF, 1'b1);
		// brackets past the stack depth
		repeat (STACK_LIMIT + 1) add_byte(lrfs_pkg::CH_OPEN);
		add_byte(8'h00, 1'b1);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				sender_idle_pct = 59;
				receiver_idle_pct = 9;
			end else if (p == 4) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_expected(phase_cfg[p]);
			target = (phase_cfg[p] > FIELD_LIMIT) ? FIELD_LIMIT : int'(phase_cfg[p]);
			if (target == 0)
				target = 1;
			start_count = bytes_queued;
			while (bytes_queued - start_count < phase_items[p]) begin
				pick = $urandom_range(99);
				if (pick < 70)
					queue_record(target);
				else if (pick < 85)
					queue_record(($urandom_range(1) == 1 || target == 1) ? target + 1 : target - 1);
				else
					queue_noise();
				// hold off the sender once until everything has drained
				if (p == 1 && bytes_queued - start_count >= phase_items[p] / 2 &&
						bytes_queued - start_count < phase_items[p] / 2 + 40) begin
					wait_idle();
					start_count = start_count - 40;
				end
			end
			wait_idle();
		end

		$display("covered %0d bytes in %0d records over %0d field count settings",
			bytes_sent, records_sent, cfg_writes);
		$display("flags seen: too many %0d, wrong count %0d, unmatched %0d, overflow %0d",
			status_count[lrfs_pkg::ST_TOO_MANY], status_count[lrfs_pkg::ST_WRONG_CNT],
			status_count[lrfs_pkg::ST_UNMATCHED], status_count[lrfs_pkg::ST_OVERFLOW]);
		if (mismatch_count == 0)
			$display("[log_record_field_splitter_top] OK");
		else
			$display("[log_record_field_splitter_top] ERROR");
		$finish;
	end

	initial begin
		#400_000;
		$display("timeout with %0d results still pending", expected_splits.size());
		$display("[log_record_field_splitter_top] ERROR");
		$finish;
	end

endmodule
